// ===== rtl/core/dpnpe_pkg.sv =====
// ----------------------------------------------------------------------------
// dpnpe_pkg
// Shared types and constants of the DPCM nibble-pair encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dpnpe_pkg;

  // Entries in one chunk before its flag bytes and entries are sent.
  localparam int CHUNK_ENTRIES = 16;
  // Chunk store size; the flag word has one bit per store entry.
  localparam int STORE_DEPTH   = 16;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
  localparam int DELTA_LIMIT   = 7;

  // Entry queue between front and back.
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  // One chunk entry as decided by the front end.
  typedef struct packed {
    logic [7:0] data;     // raw sample or packed delta pair
    logic       is_pair;  // flag bit of the entry
    logic       last;     // final entry of the stream: flush after it
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FLAG_HI,
    ST_FLAG_LO,
    ST_ENTRIES
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dpcm_nibble_pair_encoder.sv =====
// ----------------------------------------------------------------------------
// dpcm_nibble_pair_encoder
// Lossless 8-bit DPCM encoder packing pairs of small deltas into one byte.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one beat per sample, with tlast on
//   the last sample of a stream. Compressed bytes leave on m_axis, with tlast
//   on the final byte of the stream; after it a new stream begins.
//   The front end keeps one sample of lookahead and decides each chunk entry;
//   a four-entry queue passes the entries to the back end, which stores them
//   and sends every chunk as two flag bytes, high first, then its entries.
// Throughput: a sample is taken every cycle when it yields at most one entry
//   and the queue is not full; a sample that yields two entries holds off the
//   next sample until its second entry is queued. While a chunk goes out the
//   back end sends one byte per cycle while m_axis_tready allows and drains no
//   entries, so the front stalls once the queue is full.
// Order: the entry that closes a chunk is popped from the queue when the back
//   end is collecting; ST_FLAG_HI then loads the first flag byte for output.
// Reset: rst (synchronous) empties the queue and the chunk and starts a new
//   stream. When m_axis_tready is low the output register holds its byte,
//   the back end waits to send, and s_axis_tready falls once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcm_nibble_pair_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] sample
  input  wire logic       s_axis_tlast,   // final_sample
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // stream_done
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  dpnpe_pkg::entry_t q_in;
  dpnpe_pkg::entry_t q_out;

  dpnpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .in_final  (s_axis_tlast),
    .push      (q_push),
    .push_data (q_in),
    .q_full    (q_full)
  );

  dpnpe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  dpnpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_done  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dpnpe_ram.sv =====
// ----------------------------------------------------------------------------
// dpnpe_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dpnpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpnpe_fifo.sv =====
// ----------------------------------------------------------------------------
// dpnpe_fifo
// Short entry queue that decouples the classifying front from the chunk back.
// ----------------------------------------------------------------------------
`default_nettype none

module dpnpe_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dpnpe_pkg::entry_t push_data,
  input  wire logic              pop,
  output dpnpe_pkg::entry_t      pop_data,
  output logic                   full,
  output logic                   empty
);

  dpnpe_pkg::entry_t                     slots [dpnpe_pkg::FIFO_DEPTH];
  logic [dpnpe_pkg::FIFO_PTR_W-1:0]      wr_ptr;
  logic [dpnpe_pkg::FIFO_PTR_W-1:0]      rd_ptr;
  logic [dpnpe_pkg::FIFO_CNT_W-1:0]      count;

  assign full     = (count == dpnpe_pkg::FIFO_CNT_W'(dpnpe_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpnpe_front.sv =====
// ----------------------------------------------------------------------------
// dpnpe_front
// Accepts samples, keeps the lookahead and reference, and classifies each
// sample pair into packed or raw chunk entries for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpnpe_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_sample,
  input  wire logic              in_final,
  output logic                   push,
  output dpnpe_pkg::entry_t      push_data,
  input  wire logic              q_full
);

  localparam logic signed [8:0] LIMIT = 9'(dpnpe_pkg::DELTA_LIMIT);

  logic [7:0]        reference_sample;
  logic [7:0]        held_sample;
  logic              held_valid;
  logic              pend_valid;
  dpnpe_pkg::entry_t pend;

  logic [7:0]        reference_sample_next;
  logic [7:0]        held_sample_next;
  logic              held_valid_next;

  logic signed [8:0] d;
  logic signed [8:0] dn;
  logic              pair_ok;
  logic              accept;
  logic              e0_valid;
  logic              e1_valid;
  dpnpe_pkg::entry_t e0;
  dpnpe_pkg::entry_t e1;

  // Deltas are taken at nine bits so that no 8-bit wrap enters the test.
  assign d       = $signed({held_sample[7], held_sample})
                 - $signed({reference_sample[7], reference_sample});
  assign dn      = $signed({in_sample[7], in_sample})
                 - $signed({held_sample[7], held_sample});
  assign pair_ok = (d >= -LIMIT) && (d <= LIMIT) && (dn >= -LIMIT) && (dn <= LIMIT);

  assign in_ready = !pend_valid && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    e0_valid              = 1'b0;
    e1_valid              = 1'b0;
    e0                    = '{data: in_sample, is_pair: 1'b0, last: in_final};
    e1                    = '{data: in_sample, is_pair: 1'b0, last: 1'b1};
    reference_sample_next = reference_sample;
    held_sample_next      = held_sample;
    held_valid_next       = held_valid;
    if (held_valid) begin
      e0_valid        = 1'b1;
      held_valid_next = 1'b0;
      if (pair_ok) begin
        e0                    = '{data: {dn[3:0], d[3:0]}, is_pair: 1'b1, last: in_final};
        reference_sample_next = in_sample;
      end else begin
        e0                    = '{data: held_sample, is_pair: 1'b0, last: 1'b0};
        reference_sample_next = held_sample;
        if (in_final) begin
          e1_valid              = 1'b1;
          reference_sample_next = in_sample;
        end else begin
          held_sample_next = in_sample;
          held_valid_next  = 1'b1;
        end
      end
    end else if (in_final) begin
      e0_valid = 1'b1;
    end else begin
      held_sample_next = in_sample;
      held_valid_next  = 1'b1;
    end
    // The end of a stream clears the reference and the held sample, as reset does.
    if (in_final) begin
      reference_sample_next = '0;
      held_sample_next      = '0;
      held_valid_next       = 1'b0;
    end
  end

  assign push      = accept ? e0_valid : (pend_valid && !q_full);
  assign push_data = accept ? e0 : pend;

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_sample <= '0;
      held_sample      <= '0;
      held_valid       <= 1'b0;
      pend_valid       <= 1'b0;
    end else if (accept) begin
      reference_sample <= reference_sample_next;
      held_sample      <= held_sample_next;
      held_valid       <= held_valid_next;
      pend_valid       <= e1_valid;
    end else if (pend_valid && !q_full) begin
      pend_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpnpe_back.sv =====
// ----------------------------------------------------------------------------
// dpnpe_back
// Gathers queued entries into the chunk store and sends each chunk as two
// flag bytes and its entries through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpnpe_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dpnpe_pkg::entry_t q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_done
);

  localparam logic [dpnpe_pkg::FILL_W-1:0] CHUNK_FULL =
    dpnpe_pkg::FILL_W'(dpnpe_pkg::CHUNK_ENTRIES);

  dpnpe_pkg::back_state_t               state;
  dpnpe_pkg::back_state_t               state_next;
  logic [dpnpe_pkg::FILL_W-1:0]         fill;
  logic [dpnpe_pkg::FILL_W-1:0]         fill_inc;
  logic [dpnpe_pkg::STORE_DEPTH-1:0]    flags;
  logic                                 fin;
  logic [dpnpe_pkg::IDX_W-1:0]          k;

  logic                                 adv;
  logic                                 is_end;
  logic                                 emit;
  logic [7:0]                           emit_byte;
  logic                                 emit_last;
  logic                                 ram_rd_en;
  logic [dpnpe_pkg::IDX_W-1:0]          ram_rd_addr;
  logic [7:0]                           ram_rd_data;

  assign fill_inc = fill + 1'b1;
  assign adv      = !out_valid || out_ready;
  assign is_end   = ({1'b0, k} + 1'b1) == fill;

  dpnpe_ram #(
    .WIDTH (8),
    .DEPTH (dpnpe_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (q_pop),
    .wr_addr (fill[dpnpe_pkg::IDX_W-1:0]),
    .wr_data (q_data.data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      dpnpe_pkg::ST_COLLECT: begin
        if (!q_empty && (fill_inc == CHUNK_FULL || q_data.last)) begin
          state_next = dpnpe_pkg::ST_FLAG_HI;
        end
      end
      dpnpe_pkg::ST_FLAG_HI: begin
        if (adv) begin
          state_next = dpnpe_pkg::ST_FLAG_LO;
        end
      end
      dpnpe_pkg::ST_FLAG_LO: begin
        if (adv) begin
          state_next = (fill == '0) ? dpnpe_pkg::ST_COLLECT : dpnpe_pkg::ST_ENTRIES;
        end
      end
      dpnpe_pkg::ST_ENTRIES: begin
        if (adv && is_end) begin
          // A full chunk at stream end is followed by an empty flush chunk.
          state_next = (fin && fill == CHUNK_FULL) ? dpnpe_pkg::ST_FLAG_HI
                                                   : dpnpe_pkg::ST_COLLECT;
        end
      end
      default: state_next = dpnpe_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_byte   = flags[15:8];
    emit_last   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = k + 1'b1;
    case (state)
      dpnpe_pkg::ST_COLLECT: begin
        q_pop = !q_empty;
      end
      dpnpe_pkg::ST_FLAG_HI: begin
        emit = adv;
      end
      dpnpe_pkg::ST_FLAG_LO: begin
        // The first entry is fetched while the low flag byte goes out.
        emit        = adv;
        emit_byte   = flags[7:0];
        emit_last   = fin && (fill == '0);
        ram_rd_en   = adv && (fill != '0);
        ram_rd_addr = '0;
      end
      dpnpe_pkg::ST_ENTRIES: begin
        emit      = adv;
        emit_byte = ram_rd_data;
        emit_last = fin && is_end && (fill != CHUNK_FULL);
        ram_rd_en = adv && !is_end;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_done <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpnpe_pkg::ST_COLLECT;
      fill      <= '0;
      flags     <= '0;
      fin       <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        fill  <= fill_inc;
        flags <= flags | (dpnpe_pkg::STORE_DEPTH'(q_data.is_pair)
                          << fill[dpnpe_pkg::IDX_W-1:0]);
        fin   <= q_data.last;
      end
      if (state == dpnpe_pkg::ST_FLAG_LO && adv) begin
        k <= '0;
        if (fill == '0) begin
          fin <= 1'b0;
        end
      end
      if (state == dpnpe_pkg::ST_ENTRIES && adv) begin
        k <= k + 1'b1;
        if (is_end) begin
          fill  <= '0;
          flags <= '0;
          if (!(fin && fill == CHUNK_FULL)) begin
            fin <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dpnpe_top_level_placeholder_unused.sv =====
// ----------------------------------------------------------------------------
// dpnpe_stream_guard
// A name only: no module, register or other code is declared in this file,
// so nothing holds the input sample beat and the top level uses nothing here.
// ----------------------------------------------------------------------------
`default_nettype none
`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DPCM nibble-pair encoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked samples comes first. It covers a lone final
// sample, the widest packable deltas, deltas one past the limit, a jump
// across the whole sample range and a chunk that is exactly full at stream
// end. Random streams follow: mostly smooth random walks, so that pairs get
// packed, with some noisy streams mixed in. A behavioural encoder in the
// bench turns every accepted sample into the bytes it should produce. Each
// byte on the output is compared against the oldest one still outstanding.
// Both sides idle at random, and the output is held off once for a long
// stretch so that the entry queue fills and the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       stream_done;
  } enc_byte_t;

  // One row of the directed table; typed = 0 (nexp < 0 to add_row) leaves the row to the encoder model.
  typedef struct packed {
    logic [7:0]  smp;
    logic        lst;
    logic [3:0]  nexp;
    logic        typed;
    logic [31:0] exp;    // typed bytes, first one in the lowest bits
  } stim_row_t;

  localparam int RANDOM_SAMPLES = 500;
  localparam int HOLD_CYCLES    = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] sample
  logic       s_axis_tlast = 1'b0; // final_sample
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic       m_axis_tlast;        // stream_done

  int err_count = 0;

  // Encoder model state.
  logic [7:0]  mdl_ref;
  logic [7:0]  mdl_held;
  logic        mdl_held_vld;
  logic [15:0] mdl_flags;
  logic [7:0]  mdl_chunk [dpnpe_pkg::STORE_DEPTH];
  int          mdl_fill;

  enc_byte_t   sample_bytes[$];   // bytes caused by the sample just accepted
  enc_byte_t   pending_bytes[$];  // bytes still awaited from the encoder
  stim_row_t   stim_table[$];

  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   ready_run  = 0;

  dpcm_nibble_pair_encoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- model
  task automatic model_clear();
    mdl_ref      = '0;
    mdl_held     = '0;
    mdl_held_vld = 1'b0;
    mdl_flags    = '0;
    mdl_fill     = 0;
  endtask

  // Appends one expected byte to those of the current sample.
  task automatic add_byte(input logic [7:0] val, input logic done);
    enc_byte_t item;
    item.out_byte    = val;
    item.stream_done = done;
    sample_bytes     = {sample_bytes, item};
  endtask

  task automatic model_send_chunk();
    add_byte(mdl_flags[15:8], 1'b0);
    add_byte(mdl_flags[7:0], 1'b0);
    for (int k = 0; k < mdl_fill; k++)
      add_byte(mdl_chunk[k], 1'b0);
    mdl_fill  = 0;
    mdl_flags = '0;
  endtask

  task automatic model_store(input logic [7:0] val, input logic is_pair);
    mdl_chunk[mdl_fill] = val;
    if (is_pair) mdl_flags[mdl_fill] = 1'b1;
    mdl_fill++;
    if (mdl_fill >= dpnpe_pkg::CHUNK_ENTRIES) model_send_chunk();
  endtask

  // Works out the bytes that one accepted sample releases into sample_bytes.
  task automatic model_encode(input logic [7:0] smp, input logic lst);
    int        d_held;
    int        d_next;
    logic      smp_left;
    sample_bytes.delete();
    smp_left = 1'b1;
    if (mdl_held_vld) begin
      d_held = int'($signed(mdl_held)) - int'($signed(mdl_ref));
      d_next = int'($signed(smp)) - int'($signed(mdl_held));
      if (d_held >= -dpnpe_pkg::DELTA_LIMIT && d_held <= dpnpe_pkg::DELTA_LIMIT &&
          d_next >= -dpnpe_pkg::DELTA_LIMIT && d_next <= dpnpe_pkg::DELTA_LIMIT) begin
        model_store({d_next[3:0], d_held[3:0]}, 1'b1);
        mdl_ref  = smp;
        smp_left = 1'b0;
      end else begin
        model_store(mdl_held, 1'b0);
        mdl_ref = mdl_held;
      end
      mdl_held_vld = 1'b0;
    end
    if (smp_left) begin
      if (lst) begin
        model_store(smp, 1'b0);
        mdl_ref = smp;
      end else begin
        mdl_held     = smp;
        mdl_held_vld = 1'b1;
      end
    end
    if (lst) begin
      model_send_chunk();
      sample_bytes[sample_bytes.size() - 1].stream_done = 1'b1;
      model_clear();
    end
  endtask

  // -------------------------------------------------------------- sender
  task automatic send_sample(input logic [7:0] smp, input logic lst, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    model_encode(smp, lst);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(input logic [7:0] smp, input logic lst, input int nexp,
                         input logic [31:0] exp);
    stim_row_t row;
    row.smp    = smp;
    row.lst    = lst;
    row.typed  = (nexp >= 0);
    row.nexp   = (nexp >= 0) ? nexp[3:0] : 4'd0;
    row.exp    = exp;
    stim_table = {stim_table, row};
  endtask

  // ------------------------------------------------------------ receiver
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
      ready_run     <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 20);
    end else begin
      m_axis_tready <= 1'b0;
      ready_run     <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
    end
  end

  // Output checker: every byte is matched against the oldest one awaited.
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%02h last=%0b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.out_byte)
          report_mismatch($sformatf("out_byte got %02h want %02h",
                                    m_axis_tdata, want.out_byte));
        if (m_axis_tlast !== want.stream_done)
          report_mismatch($sformatf("stream_done got %0b want %0b (byte %02h)",
                                    m_axis_tlast, want.stream_done, want.out_byte));
      end
    end
  end

  // ------------------------------------------------------------ stimulus
  initial begin
    stim_row_t  row;
    logic [7:0] typed_byte;
    int         cur;
    int         len;
    int         sent;
    int         step;
    logic       noisy;
    logic [7:0] smp;

    model_clear();

    // Lone final sample, a small pair, a jump across the whole range, then the widest deltas that still pack.
    add_row(8'h80, 1'b1, 3, 32'h0080_0000);
    add_row(8'h05, 1'b0, 0, '0);
    add_row(8'h0C, 1'b1, 3, 32'h0075_0100);
    add_row(8'h7F, 1'b0, 0, '0);
    add_row(8'h80, 1'b1, 4, 32'h807F_0000);
    add_row(8'hF9, 1'b0, 0, '0);
    add_row(8'hF2, 1'b1, 3, 32'h0099_0100);
    // The second delta is one past the limit, so both go out raw.
    add_row(8'h07, 1'b0, 0, '0);
    add_row(8'h0F, 1'b1, 4, 32'h0F07_0000);
    // Fifteen raw entries and a closing pair leave the chunk exactly full at
    // stream end, so the flush carries two zero flag bytes and nothing else.
    for (int k = 0; k < 15; k++) add_row((k % 2 == 0) ? 8'd100 : 8'h9C, 1'b0, -1, '0);
    add_row(8'd103, 1'b0, -1, '0);
    add_row(8'd106, 1'b1, -1, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      send_sample(row.smp, row.lst, pick_gap());
      if (row.typed) begin
        if (sample_bytes.size() != row.nexp)
          report_mismatch($sformatf("table row %0d: model gives %0d bytes, table %0d",
                                    i, sample_bytes.size(), row.nexp));
        sample_bytes.delete();
        for (int b = 0; b < row.nexp; b++) begin
          typed_byte = row.exp[8*b +: 8];
          add_byte(typed_byte, row.lst && (b == row.nexp - 1));
        end
      end
      pending_bytes = {pending_bytes, sample_bytes};
    end

    // Random streams: smooth walks that mostly pack, plus noisy ones.
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 3);
        1:       len = $urandom_range(60, 90);
        default: len = $urandom_range(4, 40);
      endcase
      if (len > RANDOM_SAMPLES - sent) len = RANDOM_SAMPLES - sent;
      noisy = ($urandom_range(0, 4) == 0);
      cur   = int'($signed(8'($urandom_range(0, 255))));
      for (int i = 0; i < len; i++) begin
        if (noisy || $urandom_range(0, 19) == 0) begin
          cur = int'($signed(8'($urandom_range(0, 255))));
        end else begin
          step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) - 9
                                             : $urandom_range(0, 14) - 7;
          cur  = cur + step;
          if (cur > 127) cur = 127;
          if (cur < -128) cur = -128;
        end
        smp = cur[7:0];
        send_sample(smp, i == len - 1, pick_gap());
        pending_bytes = {pending_bytes, sample_bytes};
        sent++;
        if (sent == 150) hold_req <= 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout with %0d bytes still awaited", pending_bytes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
